/* rtl/mstk_pkg.sv */
// mstk_pkg: command codes, status codes and element constants for the matrix stack
// no dependencies
package mstk_pkg;
  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_STAGE  = 3'd1;
  localparam logic [2:0] KIND_SET    = 3'd2;
  localparam logic [2:0] KIND_MUL    = 3'd3;
  localparam logic [2:0] KIND_PUSH   = 3'd4;
  localparam logic [2:0] KIND_POP    = 3'd5;
  localparam logic [2:0] KIND_READ   = 3'd6;
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY = 2'd2;

  localparam int ELEMS = 16;
  localparam int ACC_W = 68;
endpackage

/* rtl/mstk_if.sv */
// mstk_cmd_if / mstk_rsp_if: valid-ready channels for command and result words
// uses no package
interface mstk_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  stack_sel;
  logic [3:0]  elem_index;
  logic signed [31:0] elem_value;
  modport source (output valid, kind, stack_sel, elem_index, elem_value, input ready);
  modport sink   (input valid, kind, stack_sel, elem_index, elem_value, output ready);
endinterface

interface mstk_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] read_value;
  logic [1:0]  status;
  logic [4:0]  top_level;
  modport source (output valid, read_value, status, top_level, input ready);
  modport sink   (input valid, read_value, status, top_level, output ready);
endinterface

/* rtl/matrix_stack_4x4.sv */
// matrix_stack_4x4: four stacks of 4x4 Q16.16 matrices held in one memory
// depends on mstk_pkg and the mstk_cmd_if / mstk_rsp_if channels
//
// usage
//  cmd carries one command word (kind, stack_sel, elem_index, elem_value);
//  rsp returns exactly one result word per command (read_value, status,
//  top_level), in order
//  one command at a time: cmd.ready is high while the sequencer is idle and
//  no result is waiting, or the waiting result is being taken
//  stage, push-refused, pop and unused kinds: result registered on accept
//  read element: memory read on accept, then the registered data is posted
//  identity and set top: one element written per cycle
//  push: one element copied per cycle through the read port
//  multiply: per result element, four top reads through the single read
//  port plus read lag; each row is then written back, and the result posted;
//  the staged operand sits in flip-flops, one product per cycle (held during
//  write-back) goes into the wide accumulator, then rounding and saturation
//  results of a row are held and written back once the row has been read
//  reset clears the stack levels and the sequencer; matrix memory is not
//  cleared; a stalled receiver holds the result word and blocks new commands
module matrix_stack_4x4 import mstk_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int NUM_STACKS  = 4
) (
  input logic clk,
  input logic rst,
  mstk_cmd_if.sink   cmd,
  mstk_rsp_if.source rsp
);
  localparam int LVL_W = $clog2(STACK_DEPTH);
  localparam int SEL_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int ADDR_W = SEL_W + LVL_W + 4;
  localparam int DEPTH_W = ADDR_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;  // identity / set top writes
  localparam logic [2:0] S_COPY = 3'd2;  // push copy
  localparam logic [2:0] S_READ = 3'd3;  // element read wait
  localparam logic [2:0] S_MUL  = 3'd4;  // multiply
  localparam logic [2:0] S_DONE = 3'd5;  // post result

  logic [31:0] mem [0:(1 << DEPTH_W) - 1];
  logic [31:0] staged [0:ELEMS-1];
  logic [LVL_W-1:0] levels [0:NUM_STACKS-1];

  logic [2:0] state;
  logic [2:0] kind;
  logic [SEL_W-1:0] sel;
  logic [LVL_W-1:0] lvl;
  logic [4:0] cnt;       // element / step counter
  logic [31:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0] wr_data;
  logic wr_en;

  // result word register
  logic rvalid;
  logic signed [31:0] r_val;
  logic [1:0] r_status;
  logic [4:0] r_level;

  // multiply datapath
  logic [1:0] row, col;
  logic [2:0] k;         // operand index; read data lags it through the memory register
  logic signed [ACC_W-1:0] acc;
  logic [31:0] row_res [0:3];
  logic [2:0] wcnt;      // row write-back counter
  logic [1:0] wrow;

  wire accept = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE) && (!rvalid || rsp.ready);
  assign rsp.valid = rvalid;
  assign rsp.read_value = r_val;
  assign rsp.status = r_status;
  assign rsp.top_level = r_level;

  wire in_range = ({1'b0, cmd.stack_sel} < (NUM_STACKS));
  wire [SEL_W-1:0] cmd_sel = SEL_W'(cmd.stack_sel);
  wire push_full = (32'(levels[cmd_sel]) >= STACK_DEPTH - 1);
  wire pop_empty = (levels[cmd_sel] == '0);

  // commands answered straight from the accepting edge
  wire quick = !in_range || (cmd.kind == KIND_STAGE) || (cmd.kind == KIND_POP) ||
               (cmd.kind == KIND_PUSH && push_full) || (cmd.kind == KIND_UNUSED);
  wire post = (accept && quick) || (state == S_DONE) ||
              (state == S_READ && cnt == 5'd1);

  function automatic logic [ADDR_W-1:0] mk_addr(logic [SEL_W-1:0] s, logic [LVL_W-1:0] l,
                                                logic [3:0] e);
    return {s, l, e};
  endfunction

  function automatic logic [31:0] round_sat(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] q;
    r = a;
    if (FRAC_BITS > 0) r = a + (ACC_W'(1) <<< (FRAC_BITS - 1));
    q = r >>> FRAC_BITS;
    if (q > ACC_W'(64'sh7FFFFFFF)) return 32'h7FFF_FFFF;
    if (q < -ACC_W'(64'sh80000000)) return 32'h8000_0000;
    return q[31:0];
  endfunction

  // product of current top element and staged element
  logic signed [63:0] prod;
  always_comb begin
    prod = $signed(rd_data) * $signed(staged[{k[1:0] - 2'd1, col}]);
  end

  // memory port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = mk_addr(sel, lvl, cnt[3:0]);
    wr_en = 1'b0;
    wr_addr = mk_addr(sel, lvl, cnt[3:0]);
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        rd_en = accept && in_range && (cmd.kind == KIND_READ);
        rd_addr = mk_addr(cmd_sel, levels[cmd_sel], cmd.elem_index);
      end
      S_FILL: begin
        wr_en = 1'b1;
        if (kind == KIND_IDENT)
          wr_data = (cnt[1:0] == cnt[3:2]) ? (32'd1 << FRAC_BITS) : 32'd0;
        else
          wr_data = staged[cnt[3:0]];
      end
      S_COPY: begin
        rd_en = !cnt[4];
        // write the element read in the previous cycle one level up
        wr_en = (cnt != 5'd0);
        wr_addr = mk_addr(sel, lvl + LVL_W'(1), cnt[3:0] - 4'd1);
      end
      S_MUL: begin
        rd_en = (k < 3'd4) && (wcnt == 3'd0);
        rd_addr = mk_addr(sel, lvl, {row, k[1:0]});
        wr_en = (wcnt != 3'd0);
        wr_addr = mk_addr(sel, lvl, {wrow, 2'(wcnt - 3'd1)});
        wr_data = row_res[2'(wcnt - 3'd1)];
      end
      default: ;
    endcase
  end

  // result word valid: set when a result is posted, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else if (post) begin
      rvalid <= 1'b1;
    end else if (rsp.ready) begin
      rvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_STACKS; i++) levels[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (accept) begin
          kind <= cmd.kind;
          sel <= cmd_sel;
          lvl <= levels[cmd_sel];
          cnt <= '0;
          r_val <= '0;
          r_status <= !in_range ? ST_OK :
                      (cmd.kind == KIND_PUSH && push_full) ? ST_PUSH_FULL :
                      (cmd.kind == KIND_POP && pop_empty) ? ST_POP_EMPTY : ST_OK;
          r_level <= !in_range ? 5'd0 :
                     (cmd.kind == KIND_POP && !pop_empty) ?
                     5'(levels[cmd_sel] - LVL_W'(1)) : 5'(levels[cmd_sel]);
          if (cmd.kind == KIND_STAGE) staged[cmd.elem_index] <= cmd.elem_value;
          if (in_range) begin
            priority case (cmd.kind)
              KIND_IDENT, KIND_SET: state <= S_FILL;
              KIND_MUL: begin
                state <= S_MUL;
                row <= '0; col <= '0; k <= '0; acc <= '0; wcnt <= '0;
              end
              KIND_PUSH: begin
                if (!push_full) state <= S_COPY;
              end
              KIND_POP: begin
                if (!pop_empty) levels[cmd_sel] <= levels[cmd_sel] - LVL_W'(1);
              end
              KIND_READ: state <= S_READ;
              default: ;
            endcase
          end
        end
        S_FILL: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) state <= S_DONE;
        end
        S_COPY: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd16) begin
            levels[sel] <= lvl + LVL_W'(1);
            r_level <= 5'(lvl + LVL_W'(1));
            state <= S_DONE;
          end
        end
        S_READ: begin
          // read data was registered at the accepting edge; post it after the wait
          cnt <= cnt + 5'd1;
          if (cnt == 5'd1) begin
            r_val <= rd_data;
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          if (wcnt != 3'd0) begin
            // row write-back, one element per cycle
            wcnt <= (wcnt == 3'd4) ? 3'd0 : wcnt + 3'd1;
            if (wcnt == 3'd4 && wrow == 2'd3) state <= S_DONE;
          end else begin
            if (k == 3'd4) begin
              row_res[col] <= round_sat(acc + ACC_W'(prod));
              acc <= '0;
              k <= '0;
              col <= col + 2'd1;
              if (col == 2'd3) begin
                wrow <= row;
                row <= row + 2'd1;
                wcnt <= 3'd1;
              end
            end else begin
              if (k != 3'd0) acc <= acc + ACC_W'(prod);
              k <= k + 3'd1;
            end
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/mstk_checker.sv */
// mstk_checker: port-level checks on the matrix stack channels, bound to the top level
// depends on mstk_pkg
module mstk_checker import mstk_pkg::*; (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic [2:0] cmd_kind,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic signed [31:0] rsp_read_value,
  input logic [1:0] rsp_status
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
    else $error("result word dropped while stalled");
  a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !cmd_ready)
    else $error("command taken while result stalled");
  a_stage_fast: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_kind == KIND_STAGE |=> rsp_valid && rsp_status == ST_OK)
    else $error("stage result late or flagged");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status != 2'd3)
    else $error("bad status code");
endmodule

bind matrix_stack_4x4 mstk_checker u_mstk_checker (
  .clk(clk), .rst(rst),
  .cmd_valid(cmd.valid), .cmd_ready(cmd.ready), .cmd_kind(cmd.kind),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_read_value(rsp.read_value), .rsp_status(rsp.status)
);

/* dv/mstk_checker.sv */
// mstk_scoreboard: watches the command and result channels of matrix_stack_4x4,
// predicts each result word and compares; depends on mstk_pkg and mstk_if
module mstk_scoreboard import mstk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mstk_cmd_if        cmd,
  mstk_rsp_if        rsp,
  output int         fail_count,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH  = 32;
  localparam int FRAC   = 16;
  localparam int STACKS = 4;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [4:0]         top_level;
  } result_t;

  logic signed [31:0] mat_mem [STACKS][DEPTH][ELEMS];
  logic signed [31:0] staged  [ELEMS];
  int                 level   [STACKS];
  result_t            expected_results [$];

  // one matrix element of top x staged: exact sum, round half up, saturate
  function automatic logic signed [31:0] dot_round(int s, int r, int c);
    logic signed [67:0] acc;
    logic signed [67:0] q;
    acc = 0;
    for (int k = 0; k < 4; k++)
      acc += 68'(mat_mem[s][level[s]][r*4+k]) * 68'(staged[k*4+c]);
    acc += 68'sd1 <<< (FRAC - 1);
    q = acc >>> FRAC;
    if (q > 68'sd2147483647) return 32'sh7FFFFFFF;
    if (q < -68'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic result_t predict_command(logic [2:0] kind, logic [1:0] sel,
                                              logic [3:0] idx, logic signed [31:0] val);
    result_t            res;
    int                 s;
    logic signed [31:0] prod [ELEMS];
    res = '0;
    s = sel;
    if (kind == KIND_STAGE) staged[idx] = val;
    case (kind)
      KIND_IDENT: begin
        for (int i = 0; i < ELEMS; i++)
          mat_mem[s][level[s]][i] = (i % 5 == 0) ? (32'sd1 <<< FRAC) : 32'sd0;
      end
      KIND_SET: begin
        for (int i = 0; i < ELEMS; i++) mat_mem[s][level[s]][i] = staged[i];
      end
      KIND_MUL: begin
        for (int i = 0; i < ELEMS; i++) prod[i] = dot_round(s, i / 4, i % 4);
        for (int i = 0; i < ELEMS; i++) mat_mem[s][level[s]][i] = prod[i];
      end
      KIND_PUSH: begin
        if (level[s] >= DEPTH - 1) begin
          res.status = ST_PUSH_FULL;
        end else begin
          for (int i = 0; i < ELEMS; i++) mat_mem[s][level[s]+1][i] = mat_mem[s][level[s]][i];
          level[s]++;
        end
      end
      KIND_POP: begin
        if (level[s] == 0) res.status = ST_POP_EMPTY;
        else level[s]--;
      end
      KIND_READ: res.read_value = mat_mem[s][level[s]][idx];
      default: ;
    endcase
    res.top_level = 5'(level[s]);
    return res;
  endfunction

  assign outstanding = expected_results.size();

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      fail_count <= 0;
      for (int s = 0; s < STACKS; s++) level[s] = 0;
      expected_results.delete();
    end else begin
      if (cmd.valid && cmd.ready)
        expected_results.push_back(predict_command(cmd.kind, cmd.stack_sel,
                                                   cmd.elem_index, cmd.elem_value));
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.read_value, rsp.status, rsp.top_level};
        if (expected_results.size() == 0) begin
          $display("%0t: result word with none expected: %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* dv/tb.sv */
// tb: top-level testbench for matrix_stack_4x4, drives commands and the
// result-side ready; depends on mstk_pkg, mstk_if, mstk_scoreboard and the rtl
module tb;
  import mstk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   send_idle_pct;   // chance in a hundred that the sender skips a cycle
  int   recv_idle_pct;   // same for the receiver
  bit   hold_off_req;    // asks the receiver for one long stall

  mstk_cmd_if cmd ();
  mstk_rsp_if rsp ();

  matrix_stack_4x4 dut (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  mstk_scoreboard chk (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp),
                       .fail_count(fail_count), .outstanding(outstanding));

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // overall limit, well beyond the slowest legal run
  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

  // receiver: random ready, plus one long hold-off on request so the
  // block fills up and back-pressures the command side
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_req = 1'b0;
      end
      rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // offer one command word and hold it until taken
  task automatic send_word(logic [2:0] kind, logic [1:0] sel, logic [3:0] idx,
                           logic signed [31:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid      <= 1'b1;
    cmd.kind       <= kind;
    cmd.stack_sel  <= sel;
    cmd.elem_index <= idx;
    cmd.elem_value <= val;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  // mostly modest Q16.16 values so products stay in range, some full-range
  function automatic logic signed [31:0] rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
    if (pick == 6) return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    return $urandom;
  endfunction

  // one random command, weighted toward work that changes the tops
  task automatic random_word();
    int                 r;
    logic [2:0]         kind;
    r = $urandom_range(0, 99);
    if (r < 30)      kind = KIND_STAGE;
    else if (r < 45) kind = KIND_MUL;
    else if (r < 60) kind = KIND_PUSH;
    else if (r < 75) kind = KIND_POP;
    else if (r < 90) kind = KIND_READ;
    else if (r < 94) kind = KIND_IDENT;
    else if (r < 98) kind = KIND_SET;
    else             kind = KIND_UNUSED;
    send_word(kind, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), rand_value());
  endtask

  initial begin
    int s;
    cmd.valid = 1'b0;
    cmd.kind = KIND_IDENT;
    cmd.stack_sel = '0;
    cmd.elem_index = '0;
    cmd.elem_value = '0;
    hold_off_req = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 48;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the staged matrix (extremes in it) and give every stack a top,
    // so nothing ever reads an unwritten word
    for (int i = 0; i < ELEMS; i++)
      send_word(KIND_STAGE, 2'(i), 4'(i),
                (i == 0) ? 32'sh7FFFFFFF : (i == 5) ? 32'sh80000000 :
                (i % 5 == 0) ? 32'sh00010000 : 32'sh00008000);
    for (int k = 0; k < 4; k++) send_word(KIND_IDENT, 2'(k), '0, '0);
    send_word(KIND_POP, 2'd0, '0, '0);           // pop refused at the bottom
    send_word(KIND_MUL, 2'd1, '0, '0);           // identity x staged
    send_word(KIND_SET, 2'd2, '0, '0);
    send_word(KIND_MUL, 2'd2, '0, '0);           // saturates on the positive side
    send_word(KIND_READ, 2'd2, 4'd0, '0);
    send_word(KIND_READ, 2'd2, 4'd15, '0);
    send_word(KIND_UNUSED, 2'd3, '0, '0);        // unused kind

    for (int n = 0; n < 1350; n++) begin
      if (n == 500) begin
        send_idle_pct = 48;
        recv_idle_pct = 22;
      end
      if (n == 1000) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == 200) hold_off_req = 1'b1;
      // twice drive one stack to full and back to the bottom,
      // hitting push refused and pop refused on the way
      if (n == 700 || n == 1200) begin
        s = $urandom_range(0, 3);
        repeat (34) send_word(KIND_PUSH, 2'(s), '0, '0);
        send_word(KIND_MUL, 2'(s), '0, '0);
        send_word(KIND_READ, 2'(s), 4'($urandom_range(0, 15)), '0);
        repeat (34) send_word(KIND_POP, 2'(s), '0, '0);
      end
      random_word();
    end
    cmd.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

/* matrix_stack_4x4.f */
rtl/mstk_pkg.sv
rtl/mstk_if.sv
rtl/matrix_stack_4x4.sv
rtl/mstk_checker.sv
dv/mstk_checker.sv
dv/tb.sv
